/* hw/rtl/swqt_pkg.sv */
package swqt_pkg;

  localparam int NUM_PROC = 32;
  localparam int PID_W    = 5;
  localparam int KEY_W    = 32;

  localparam logic [1:0] CMD_BLOCK  = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DROP   = 2'd2;
  localparam logic [1:0] CMD_PEEK   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOFREE   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load_in;
    logic look;
    logic exec;
    logic unlink;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic need_unlink;
    logic out_busy;
  } stat_t;

endpackage

/* hw/rtl/swqt_ctrl.sv */
module swqt_ctrl
  import swqt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  input  stat_t stat,
  output ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_UNLINK = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    ctrl          = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_LOOK;
        end
      end
      S_LOOK: begin
        ctrl.look  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = S_DONE;
      end
      S_UNLINK: begin
        ctrl.unlink = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.need_unlink) begin
          state_next = S_UNLINK;
        end else if (!stat.out_busy) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !stat.need_unlink && !stat.out_busy) |=> (state == S_IDLE))
    else $error("result load did not return to idle");
  a_unlink_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNLINK) |=> (state == S_DONE))
    else $error("unlink step not followed by done");
  a_load_not_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> !stat.out_busy)
    else $error("result loaded over a held word");
`endif

endmodule

/* hw/rtl/swqt_dp.sv */
module swqt_dp
  import swqt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctrl_t            ctrl,
  output stat_t            stat,
  input  logic [1:0]       command,
  input  logic [KEY_W-1:0] sem_key,
  input  logic [PID_W-1:0] process_id,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic [1:0]       status,
  output logic [PID_W-1:0] result_process,
  output logic             result_valid
);

  // Latched command.
  logic [1:0]       c_cmd;
  logic [KEY_W-1:0] c_key;
  logic [PID_W-1:0] c_pid;

  // Descriptor and process state.
  logic [KEY_W-1:0] desc_key [NUM_PROC];
  logic [KEY_W-1:0] wait_key [NUM_PROC];
  logic [PID_W-1:0] q_head   [NUM_PROC];
  logic [PID_W-1:0] q_tail   [NUM_PROC];
  logic [PID_W-1:0] p_next   [NUM_PROC];
  logic [PID_W-1:0] p_prev   [NUM_PROC];
  logic             p_hn     [NUM_PROC];
  logic             p_hp     [NUM_PROC];

  // Lookup results.
  logic             hit;
  logic             free_ok;
  logic             wk_nz;
  logic [PID_W-1:0] d_idx;
  logic [PID_W-1:0] f_idx;

  // Pending unlink and result.
  logic             need_unlink;
  logic [PID_W-1:0] u_p;
  logic [1:0]       res_status;
  logic [PID_W-1:0] res_proc;
  logic             res_valid;

  logic [KEY_W-1:0]    srch;
  logic [NUM_PROC-1:0] match;
  logic                m_any;
  logic                f_any;
  logic [PID_W-1:0]    m_idx;
  logic [PID_W-1:0]    fr_idx;

  assign srch = (c_cmd == CMD_DROP) ? wait_key[c_pid] : c_key;

  always_comb begin
    m_any  = 1'b0;
    f_any  = 1'b0;
    m_idx  = '0;
    fr_idx = '0;
    for (int i = NUM_PROC - 1; i >= 0; i--) begin
      match[i] = (desc_key[i] == srch);
      if (match[i]) begin
        m_any = 1'b1;
        m_idx = PID_W'(i);
      end
      if (desc_key[i] == '0) begin
        f_any  = 1'b1;
        fr_idx = PID_W'(i);
      end
    end
  end

  // Unlink operands.
  logic [PID_W-1:0] pv;
  logic [PID_W-1:0] nx;
  logic             hp;
  logic             hn;

  assign pv = p_prev[u_p];
  assign nx = p_next[u_p];
  assign hp = p_hp[u_p];
  assign hn = p_hn[u_p];

  assign stat.need_unlink = need_unlink;
  assign stat.out_busy    = rsp_valid & rsp_stall;

  // Control registers and resettable tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      need_unlink <= 1'b0;
      rsp_valid   <= 1'b0;
      for (int i = 0; i < NUM_PROC; i++) begin
        desc_key[i] <= '0;
        wait_key[i] <= '0;
      end
    end else begin
      if (ctrl.exec) begin
        need_unlink <= 1'b0;
        if (c_cmd == CMD_BLOCK) begin
          if (c_key != '0 && !wk_nz) begin
            if (hit) begin
              wait_key[c_pid] <= c_key;
            end else if (free_ok) begin
              desc_key[f_idx] <= c_key;
              wait_key[c_pid] <= c_key;
            end
          end
        end else if (c_cmd == CMD_DROP) begin
          need_unlink <= wk_nz && hit;
        end else if (c_cmd == CMD_REMOVE) begin
          need_unlink <= (c_key != '0) && hit;
        end
      end
      if (ctrl.unlink) begin
        need_unlink   <= 1'b0;
        wait_key[u_p] <= '0;
        if (!hp && !hn) begin
          desc_key[d_idx] <= '0;
        end
      end
      if (ctrl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers and link tables.
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      c_cmd <= command;
      c_key <= sem_key;
      c_pid <= process_id;
    end
    if (ctrl.look) begin
      hit     <= m_any;
      d_idx   <= m_idx;
      free_ok <= f_any;
      f_idx   <= fr_idx;
      wk_nz   <= (wait_key[c_pid] != '0);
    end
    if (ctrl.exec) begin
      res_status <= ST_OK;
      res_proc   <= '0;
      res_valid  <= 1'b0;
      u_p        <= c_pid;
      if (c_cmd == CMD_BLOCK) begin
        if (c_key == '0 || wk_nz) begin
          res_status <= ST_INVALID;
        end else if (hit) begin
          p_next[q_tail[d_idx]] <= c_pid;
          p_hn[q_tail[d_idx]]   <= 1'b1;
          p_prev[c_pid]         <= q_tail[d_idx];
          p_hp[c_pid]           <= 1'b1;
          p_hn[c_pid]           <= 1'b0;
          q_tail[d_idx]         <= c_pid;
        end else if (free_ok) begin
          d_idx         <= f_idx;
          q_head[f_idx] <= c_pid;
          q_tail[f_idx] <= c_pid;
          p_hn[c_pid]   <= 1'b0;
          p_hp[c_pid]   <= 1'b0;
        end else begin
          res_status <= ST_NOFREE;
        end
      end else if (c_cmd == CMD_DROP) begin
        if (!wk_nz || !hit) begin
          res_status <= ST_NOTFOUND;
        end else begin
          res_proc  <= c_pid;
          res_valid <= 1'b1;
        end
      end else begin
        if (c_key == '0) begin
          res_status <= ST_INVALID;
        end else if (!hit) begin
          res_status <= ST_NOTFOUND;
        end else begin
          res_proc  <= q_head[d_idx];
          res_valid <= 1'b1;
          u_p       <= q_head[d_idx];
        end
      end
    end
    if (ctrl.unlink) begin
      p_hn[u_p] <= 1'b0;
      p_hp[u_p] <= 1'b0;
      if (hp) begin
        p_next[pv] <= nx;
        p_hn[pv]   <= hn;
      end else if (hn) begin
        q_head[d_idx] <= nx;
      end
      if (hn) begin
        p_prev[nx] <= pv;
        p_hp[nx]   <= hp;
      end else if (hp) begin
        q_tail[d_idx] <= pv;
      end
    end
    if (ctrl.load_out) begin
      status         <= res_status;
      result_process <= res_proc;
      result_valid   <= res_valid;
    end
  end

`ifndef ASSERT_OFF
  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    (ctrl.look && srch != '0) |-> $onehot0(match))
    else $error("two descriptors hold the same key");
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && result_valid) |-> (status == ST_OK))
    else $error("process returned with error status");
  a_unlink_has_hit: assert property (@(posedge clk) disable iff (rst)
    ctrl.unlink |-> (hit && res_valid))
    else $error("unlink without a found descriptor");
`endif

endmodule

/* hw/rtl/semaphore_wait_queue_table.sv */
// Semaphore wait-queue table: up to 32 descriptors, each keyed by a nonzero
// 32-bit semaphore address and holding a FIFO of blocked process ids as a
// doubly linked list. A command word is accepted only while the block is
// idle; it then passes through a step for the parallel key compare across
// all descriptors, a step for the decision and the link update, and a step
// in which the result word is loaded into the output register. Remove head
// and remove process that succeed add a step for the link splice before
// coming back to the load. The block returns to idle as the result word is
// loaded, so the next command can be accepted while that result is
// presented. The result register is held while the result side stalls; a
// held result only delays the loading of the following one. The queue and
// link tables need no clearing after reset and the block is ready at once.
module semaphore_wait_queue_table
  import swqt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  logic [1:0]       command,
  input  logic [KEY_W-1:0] sem_key,
  input  logic [PID_W-1:0] process_id,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic [1:0]       status,
  output logic [PID_W-1:0] result_process,
  output logic             result_valid
);

  // Commands from the sequencer and status back from the datapath.
  ctrl_t ctrl;
  stat_t stat;

  swqt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  swqt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .command        (command),
    .sem_key        (sem_key),
    .process_id     (process_id),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .result_process (result_process),
    .result_valid   (result_valid)
  );

endmodule
